// File: sv/ppor_pkg.sv
package ppor_pkg;

  localparam int OFFSET_BITS      = 28;
  localparam int MAP_W            = 18;
  localparam int LOW_W            = 20;
  localparam int SHIFT_W          = 5;
  localparam int SEG_CALC_W       = 32;
  localparam int PAGE_CALC_W      = MAP_W + (1 << SHIFT_W) - 1;
  localparam int PADDR_W          = 4;
  localparam int DEF_SEG_ENTRIES  = 262144;
  localparam int DEF_NUM_PAGES    = 16384;

  localparam logic [SHIFT_W-1:0] RST_SEGMENT_SHIFT = SHIFT_W'(10);
  localparam logic [SHIFT_W-1:0] RST_PAGE_SHIFT    = SHIFT_W'(14);
  localparam logic               RST_USE_PREFERRED = 1'b1;
  localparam logic [MAP_W-1:0]   MAP_ALL_ONES      = {MAP_W{1'b1}};

  localparam logic [1:0] REG_SEGMENT_SHIFT = 2'd0;
  localparam logic [1:0] REG_PAGE_SHIFT    = 2'd1;
  localparam logic [1:0] REG_USE_PREFERRED = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_PREMARK = 2'd2,
    MODE_CAND    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic [OFFSET_BITS-1:0]  candidate_offset;
    logic                    first_candidate;
    logic                    last_candidate;
    logic [MAP_W-1:0]        table_index;
    logic [MAP_W-1:0]        table_value;
  } in_word_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]  remap_offset;
    logic                    hit_marked_page;
  } out_word_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]  segment_shift;
    logic [SHIFT_W-1:0]  page_shift;
    logic                use_preferred;
  } cfg_t;

  // page number of a mapped segment
  function automatic logic [PAGE_CALC_W-1:0] page_of(input logic [MAP_W-1:0] mapped,
                                                      input logic [SHIFT_W-1:0] seg_sh,
                                                      input logic [SHIFT_W-1:0] page_sh);
    logic [PAGE_CALC_W-1:0] byte_addr;
    byte_addr = PAGE_CALC_W'(mapped) << seg_sh;
    return byte_addr >> page_sh;
  endfunction

endpackage

// File: sv/ppor_ram.sv
module ppor_ram import ppor_pkg::*; #(
  parameter int WIDTH = MAP_W,
  parameter int DEPTH = DEF_SEG_ENTRIES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ppor_core.sv
module ppor_core import ppor_pkg::*; #(
  parameter int SEG_ENTRIES  = DEF_SEG_ENTRIES,
  parameter int NUM_PAGES    = DEF_NUM_PAGES,
  localparam int SEG_AW = $clog2(SEG_ENTRIES),
  localparam int PG_AW  = $clog2(NUM_PAGES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  output logic              seg_we,
  output logic [SEG_AW-1:0] seg_waddr,
  output logic [MAP_W-1:0]  seg_wdata,
  output logic [SEG_AW-1:0] seg_raddr,
  input  logic [MAP_W-1:0]  seg_rdata,
  output logic              mark_we,
  output logic [PG_AW-1:0]  mark_waddr,
  output logic              mark_wdata,
  output logic [PG_AW-1:0]  mark_raddr,
  input  logic              mark_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_PAGE,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  in_word_t         item_r, item_nxt;
  logic             seg_oor_r, seg_oor_nxt;
  logic [MAP_W-1:0] mapped_r, mapped_nxt;
  logic             page_oor_r, page_oor_nxt;
  logic             hit_r, hit_nxt;
  logic [MAP_W-1:0] best_r, best_nxt;
  logic [LOW_W-1:0] low_r, low_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;
  logic [PG_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                   accept;
  logic [SEG_CALC_W-1:0]  seg_full;
  logic [SEG_CALC_W-1:0]  tidx_full;
  logic [MAP_W-1:0]       mapped;
  logic [MAP_W-1:0]       page_src;
  logic [PAGE_CALC_W-1:0] page_full;
  logic                   page_oor;
  logic [OFFSET_BITS-1:0] low_mask;
  logic [LOW_W-1:0]       low_in;
  logic                   marked;
  logic                   emit_ok;
  logic                   hit_e;
  logic [MAP_W-1:0]       best_e;
  logic [LOW_W-1:0]       low_e;
  logic [PAGE_CALC_W-1:0] best_wide;
  logic [OFFSET_BITS-1:0] new_off;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign seg_full  = SEG_CALC_W'(in_data.candidate_offset) >> cfg.segment_shift;
  assign seg_raddr = seg_full[SEG_AW-1:0];
  assign tidx_full = SEG_CALC_W'(in_data.table_index);
  assign seg_we    = accept && (in_data.mode == MODE_LOAD) &&
                     (tidx_full < SEG_CALC_W'(SEG_ENTRIES));
  assign seg_waddr = tidx_full[SEG_AW-1:0];
  assign seg_wdata = in_data.table_value;

  assign mapped     = seg_oor_r ? '0 : seg_rdata;
  assign page_src   = (state_r == S_FIN) ? best_r : mapped;
  assign page_full  = page_of(page_src, cfg.segment_shift, cfg.page_shift);
  assign page_oor   = (page_full >= PAGE_CALC_W'(NUM_PAGES));
  assign mark_raddr = page_full[PG_AW-1:0];

  assign low_mask = ~({OFFSET_BITS{1'b1}} << cfg.segment_shift);
  assign low_in   = LOW_W'(item_r.candidate_offset & low_mask);
  assign marked   = !page_oor_r && mark_rdata;
  assign emit_ok  = !out_valid_r || !out_stall;

  assign hit_e  = item_r.first_candidate ? 1'b0 : hit_r;
  assign best_e = item_r.first_candidate ? MAP_ALL_ONES : best_r;
  assign low_e  = item_r.first_candidate ? '0 : low_r;

  assign best_wide = PAGE_CALC_W'(best_r) << cfg.segment_shift;
  assign new_off   = best_wide[OFFSET_BITS-1:0] + OFFSET_BITS'(low_r);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    seg_oor_nxt   = seg_oor_r;
    mapped_nxt    = mapped_r;
    page_oor_nxt  = page_oor_r;
    hit_nxt       = hit_r;
    best_nxt      = best_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    clr_cnt_nxt   = clr_cnt_r;
    mark_we       = 1'b0;
    mark_waddr    = mark_raddr;
    mark_wdata    = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        mark_we     = 1'b1;
        mark_waddr  = clr_cnt_r;
        mark_wdata  = 1'b0;
        clr_cnt_nxt = clr_cnt_r + PG_AW'(1);
        if (clr_cnt_r == PG_AW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt    = in_data;
          seg_oor_nxt = (seg_full >= SEG_CALC_W'(SEG_ENTRIES));
          unique case (in_data.mode) inside
            MODE_CLEAR: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
              hit_nxt     = 1'b0;
              best_nxt    = MAP_ALL_ONES;
              low_nxt     = '0;
            end
            MODE_LOAD: begin
              state_nxt = S_IDLE;
            end
            MODE_PREMARK, MODE_CAND: begin
              state_nxt = S_MAP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MAP: begin
        mapped_nxt   = mapped;
        page_oor_nxt = page_oor;
        if (item_r.mode == MODE_PREMARK) begin
          mark_we   = !page_oor;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PAGE;
        end
      end
      S_PAGE: begin
        hit_nxt  = hit_e;
        best_nxt = best_e;
        low_nxt  = low_e;
        if (!hit_e) begin
          if (cfg.use_preferred && marked) begin
            hit_nxt  = 1'b1;
            best_nxt = mapped_r;
            low_nxt  = low_in;
          end else if (item_r.first_candidate || (mapped_r < best_e)) begin
            best_nxt = mapped_r;
            low_nxt  = low_in;
          end
        end
        state_nxt = item_r.last_candidate ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{remap_offset: new_off, hit_marked_page: hit_r};
          mark_we       = !hit_r && !page_oor;
          hit_nxt       = 1'b0;
          best_nxt      = MAP_ALL_ONES;
          low_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hit_r       <= 1'b0;
      best_r      <= MAP_ALL_ONES;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hit_r       <= hit_nxt;
      best_r      <= best_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    seg_oor_r  <= seg_oor_nxt;
    mapped_r   <= mapped_nxt;
    page_oor_r <= page_oor_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/page_preferring_offset_remap_top.sv
// Remaps copy-factor offsets so the factors of a block cluster into few
// dictionary pages. Candidate words go through a segment-table RAM and then a
// page-mark RAM, one read after the other, and only one word is in flight;
// the result for the last candidate of a factor may wait for a free output
// register. A block clear sweeps the page-mark RAM one entry per cycle; the
// same sweep runs after reset, and in_stall stays high until it is done, so
// no word is taken before then. The segment table holds garbage until
// loaded. Registers (APB, 4 bytes apart): segment_shift at 0x0, page_shift
// at 0x4, use_preferred at 0x8.
module page_preferring_offset_remap_top import ppor_pkg::*; #(
  parameter int SEG_ENTRIES  = DEF_SEG_ENTRIES,
  parameter int NUM_PAGES    = DEF_NUM_PAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data
);

  localparam int SEG_AW = $clog2(SEG_ENTRIES);
  localparam int PG_AW  = $clog2(NUM_PAGES);

  logic [SHIFT_W-1:0] segment_shift_r;
  logic [SHIFT_W-1:0] page_shift_r;
  logic               use_preferred_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  cfg_t               cfg;

  logic              seg_we;
  logic [SEG_AW-1:0] seg_waddr;
  logic [MAP_W-1:0]  seg_wdata;
  logic [SEG_AW-1:0] seg_raddr;
  logic [MAP_W-1:0]  seg_rdata;
  logic              mark_we;
  logic [PG_AW-1:0]  mark_waddr;
  logic              mark_wdata;
  logic [PG_AW-1:0]  mark_raddr;
  logic              mark_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_shift_r <= RST_SEGMENT_SHIFT;
      page_shift_r    <= RST_PAGE_SHIFT;
      use_preferred_r <= RST_USE_PREFERRED;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEGMENT_SHIFT: segment_shift_r <= pwdata[SHIFT_W-1:0];
        REG_PAGE_SHIFT:    page_shift_r    <= pwdata[SHIFT_W-1:0];
        REG_USE_PREFERRED: use_preferred_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEGMENT_SHIFT: prdata = 32'(segment_shift_r);
      REG_PAGE_SHIFT:    prdata = 32'(page_shift_r);
      REG_USE_PREFERRED: prdata = 32'(use_preferred_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{segment_shift: segment_shift_r,
                 page_shift:    page_shift_r,
                 use_preferred: use_preferred_r};

  ppor_ram #(
    .WIDTH (MAP_W),
    .DEPTH (SEG_ENTRIES)
  ) u_seg_map (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  ppor_ram #(
    .WIDTH (1),
    .DEPTH (NUM_PAGES)
  ) u_page_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  ppor_core #(
    .SEG_ENTRIES  (SEG_ENTRIES),
    .NUM_PAGES    (NUM_PAGES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .seg_we     (seg_we),
    .seg_waddr  (seg_waddr),
    .seg_wdata  (seg_wdata),
    .seg_raddr  (seg_raddr),
    .seg_rdata  (seg_rdata),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata)
  );

`ifndef NO_ASSERTIONS
  a_seg_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    seg_we |-> (in_valid && !in_stall && (in_data.mode == MODE_LOAD)))
    else $error("segment table written without an accepted load word");

  a_mark_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mark_we |-> in_stall)
    else $error("page mark written while input side is open");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.mode != MODE_LOAD)) |=> in_stall)
    else $error("input not stalled while a word is in flight");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in flight");
`endif

endmodule

// File: tb/sv/page_preferring_offset_remap_top_tb.sv
module page_preferring_offset_remap_top_tb;
  import ppor_pkg::*;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } dir_row_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;

  page_preferring_offset_remap_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // model state
  logic [MAP_W-1:0]   seg_map [DEF_SEG_ENTRIES];
  bit                 page_mark [DEF_NUM_PAGES];
  bit                 factor_hit;
  logic [MAP_W-1:0]   best_seg;
  logic [LOW_W-1:0]   best_low;
  logic [SHIFT_W-1:0] seg_sh   = RST_SEGMENT_SHIFT;
  logic [SHIFT_W-1:0] page_sh  = RST_PAGE_SHIFT;
  logic               use_pref = RST_USE_PREFERRED;

  out_word_t   pending_remaps[$];
  int unsigned loaded_segs[$];
  dir_row_t    dir_rows[$];
  out_word_t   want;

  int errors      = 0;
  int words_sent  = 0;
  int remaps_seen = 0;
  int hits_seen   = 0;
  int settings    = 1;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_kind  = 0;

  function automatic void drop_factor();
    factor_hit = 1'b0;
    best_seg   = MAP_ALL_ONES;
    best_low   = '0;
  endfunction

  function automatic logic [MAP_W-1:0] map_of(input logic [OFFSET_BITS-1:0] off);
    logic [63:0] s;
    s = 64'(off) >> seg_sh;
    if (s >= DEF_SEG_ENTRIES) return '0;
    return seg_map[s[MAP_W-1:0]];
  endfunction

  function automatic logic [63:0] page_num(input logic [MAP_W-1:0] m);
    return (64'(m) << seg_sh) >> page_sh;
  endfunction

  function automatic void mark(input logic [63:0] pg);
    if (pg < DEF_NUM_PAGES) page_mark[int'(pg)] = 1'b1;
  endfunction

  task automatic remap_predict(input in_word_t w, output bit produced, output out_word_t r);
    logic [MAP_W-1:0] m;
    logic [LOW_W-1:0] lo;
    logic [63:0]      pg;
    logic [63:0]      full;
    produced = 1'b0;
    r = '0;
    case (w.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < DEF_NUM_PAGES; i++) page_mark[i] = 1'b0;
        drop_factor();
      end
      MODE_LOAD: seg_map[w.table_index] = w.table_value;
      MODE_PREMARK: mark(page_num(map_of(w.candidate_offset)));
      default: begin
        if (w.first_candidate) drop_factor();
        if (!factor_hit) begin
          m  = map_of(w.candidate_offset);
          lo = LOW_W'(64'(w.candidate_offset) & ((64'd1 << seg_sh) - 64'd1));
          pg = page_num(m);
          if (use_pref && pg < DEF_NUM_PAGES && page_mark[int'(pg)]) begin
            factor_hit = 1'b1;
            best_seg   = m;
            best_low   = lo;
          end else if (w.first_candidate || m < best_seg) begin
            best_seg = m;
            best_low = lo;
          end
        end
        if (w.last_candidate) begin
          if (!factor_hit) mark(page_num(best_seg));
          full = (64'(best_seg) << seg_sh) + 64'(best_low);
          r.remap_offset    = full[OFFSET_BITS-1:0];
          r.hit_marked_page = factor_hit;
          produced = 1'b1;
          drop_factor();
        end
      end
    endcase
  endtask

  // offset whose segment was loaded, or lies past the table
  function automatic logic [OFFSET_BITS-1:0] safe_offset();
    int unsigned w;
    int unsigned pick;
    logic [63:0] off;
    if (seg_sh < 10 && $urandom_range(0, 9) == 0)
      return OFFSET_BITS'($urandom) | (OFFSET_BITS'(1) << (seg_sh + MAP_W));
    w = 0;
    for (int k = 0; k < 8; k++) begin
      pick = loaded_segs[$urandom_range(0, loaded_segs.size() - 1)];
      if ((64'(pick) << seg_sh) < (64'd1 << OFFSET_BITS)) begin
        w = pick;
        break;
      end
    end
    off = (64'(w) << seg_sh) | (64'($urandom) & ((64'd1 << seg_sh) - 64'd1));
    return off[OFFSET_BITS-1:0];
  endfunction

  function automatic in_word_t cand(input logic [OFFSET_BITS-1:0] off, input bit f, input bit l);
    in_word_t w;
    w = '0;
    w.mode = MODE_CAND;
    w.candidate_offset = off;
    w.first_candidate  = f;
    w.last_candidate   = l;
    return w;
  endfunction

  function automatic in_word_t load(input logic [MAP_W-1:0] idx, input logic [MAP_W-1:0] val);
    in_word_t w;
    w = '0;
    w.mode = MODE_LOAD;
    w.table_index = idx;
    w.table_value = val;
    loaded_segs = {loaded_segs, 32'(idx)};
    return w;
  endfunction

  function automatic in_word_t op_word(input mode_t md, input logic [OFFSET_BITS-1:0] off);
    in_word_t w;
    w = '0;
    w.mode = md;
    w.candidate_offset = off;
    return w;
  endfunction

  function automatic in_word_t scramble(input in_word_t w);
    in_word_t r;
    r = w;
    if (w.mode != MODE_LOAD) begin
      r.table_index = MAP_W'($urandom);
      r.table_value = MAP_W'($urandom);
    end
    if (w.mode == MODE_LOAD || w.mode == MODE_CLEAR) begin
      r.candidate_offset = OFFSET_BITS'($urandom);
      r.first_candidate  = 1'($urandom_range(0, 1));
      r.last_candidate   = 1'($urandom_range(0, 1));
    end
    if (w.mode == MODE_PREMARK) begin
      r.first_candidate = 1'($urandom_range(0, 1));
      r.last_candidate  = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  function automatic void add_row(input in_word_t w, input bit typed = 1'b0,
                                  input logic [OFFSET_BITS-1:0] off = '0,
                                  input logic hit = 1'b0);
    dir_row_t row;
    row.word = w;
    row.typed = typed;
    row.result.remap_offset = off;
    row.result.hit_marked_page = hit;
    dir_rows = {dir_rows, row};
  endfunction

  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t typed_res = '0);
    int gap;
    bit produced;
    out_word_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    remap_predict(w, produced, r);
    if (produced) pending_remaps = {pending_remaps, (typed ? typed_res : r)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_remaps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      errors++;
      $display("%0t readback reg %0d: expected %h, got %h", $time, idx, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_remap_cfg(input int ss, input int ps, input bit pref);
    apb_write(REG_SEGMENT_SHIFT, 32'(ss));
    apb_write(REG_PAGE_SHIFT, 32'(ps));
    apb_write(REG_USE_PREFERRED, 32'(pref));
    seg_sh   = SHIFT_W'(ss);
    page_sh  = SHIFT_W'(ps);
    use_pref = pref;
    settings++;
  endtask

  task automatic random_phase(input int n_words, inout int clears_left);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(scramble(load($urandom_range(0, 1) ? MAP_W'($urandom_range(0, 255))
                                                     : MAP_W'($urandom),
                                $urandom_range(0, 3) ? MAP_W'($urandom_range(0, 63))
                                                     : MAP_W'($urandom))));
        sent++;
      end else if (r < 14) begin
        send_word(scramble(op_word(MODE_PREMARK, safe_offset())));
        sent++;
      end else if (r < 15 && clears_left > 0) begin
        send_word(scramble(op_word(MODE_CLEAR, '0)));
        clears_left--;
        sent++;
      end else if (r < 22) begin
        send_word(scramble(cand(safe_offset(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)))));
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_word(scramble(cand(safe_offset(), i == 0, i == len - 1)));
        sent += len;
      end
    end
    // close any open factor so nothing is in flight afterward
    send_word(scramble(cand(safe_offset(), 1'b1, 1'b1)));
    drain();
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_remaps.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, got %h", $time, out_data);
      end else begin
        want = pending_remaps.pop_front();
        remaps_seen++;
        if (out_data.hit_marked_page === 1'b1) hits_seen++;
        if (out_data.remap_offset !== want.remap_offset) begin
          errors++;
          $display("%0t remap_offset: expected %h, got %h", $time,
                   want.remap_offset, out_data.remap_offset);
        end
        if (out_data.hit_marked_page !== want.hit_marked_page) begin
          errors++;
          $display("%0t hit_marked_page: expected %b, got %b", $time,
                   want.hit_marked_page, out_data.hit_marked_page);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("page_preferring_offset_remap_top verification failed");
    $finish;
  end

  initial begin
    int clears_left;
    out_word_t typed_res;
    drop_factor();
    clears_left = 5;

    add_row(load(18'd0, 18'd0));
    add_row(load(18'd1, 18'd100));
    add_row(load(18'd2, 18'd40));
    add_row(load(18'd3, 18'd30));
    add_row(load(18'h3FFFF, 18'h3FFFF));
    add_row(cand(28'h00003FF, 1'b1, 1'b1), 1'b1, 28'h00003FF, 1'b0);
    add_row(cand(28'h0000001, 1'b1, 1'b1), 1'b1, 28'h0000001, 1'b1);
    add_row(cand(28'hFFFFFFF, 1'b1, 1'b1), 1'b1, 28'hFFFFFFF, 1'b0);
    add_row(op_word(MODE_PREMARK, 28'h0000555));
    // marked page found on the last candidate of a run
    add_row(cand(28'h0000AAA, 1'b1, 1'b0));
    add_row(cand(28'h0000C0F, 1'b0, 1'b0));
    add_row(cand(28'h0000555, 1'b0, 1'b1));
    // no marked page: smallest mapped segment wins
    add_row(cand(28'h0000AAA, 1'b1, 1'b0));
    add_row(cand(28'h0000C0F, 1'b0, 1'b1));
    // rest of the run ignored after a hit
    add_row(cand(28'h0000C0F, 1'b1, 1'b0));
    add_row(cand(28'h0000000, 1'b0, 1'b0));
    add_row(cand(28'h0000AAA, 1'b0, 1'b1));
    // run with no opening candidate
    add_row(cand(28'h0000AAA, 1'b0, 1'b1));
    // block clear drops the open factor
    add_row(cand(28'h0000AAA, 1'b1, 1'b0));
    add_row(op_word(MODE_CLEAR, '0));
    add_row(cand(28'h0000010, 1'b0, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_res = dir_rows[i].result;
      send_word(dir_rows[i].word, dir_rows[i].typed, typed_res);
    end
    drain();

    set_remap_cfg(0, 0, 1'b0);
    random_phase(55, clears_left);
    set_remap_cfg(0, 27, 1'b1);
    random_phase(55, clears_left);
    set_remap_cfg(20, 27, 1'b1);
    random_phase(55, clears_left);
    set_remap_cfg(20, 0, 1'b1);
    random_phase(55, clears_left);
    set_remap_cfg(4, 9, 1'b1);
    random_phase(55, clears_left);
    set_remap_cfg(12, 12, 1'b0);
    random_phase(55, clears_left);
    set_remap_cfg(10, 14, 1'b1);
    random_phase(55, clears_left);

    repeat (20) @(posedge clk);
    $display("%0d words sent under %0d register settings (clears, loads, pre-marks, runs)",
             words_sent, settings);
    $display("%0d remapped offsets checked, %0d of them on a marked page, %0d mismatches",
             remaps_seen, hits_seen, errors);
    if (errors == 0 && pending_remaps.size() == 0) begin
      $display("page_preferring_offset_remap_top verification clean");
    end else begin
      $display("page_preferring_offset_remap_top verification failed");
    end
    $finish;
  end

endmodule
